FILE: sv/sco_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sco_pkg
// Shared types and constants of the size and cost aware eviction unit.
// ----------------------------------------------------------------------------
package sco_pkg;

  localparam int ENTRIES            = 32;
  localparam int RANK_FRACTION_BITS = 8;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 2);
  localparam int DIV_W  = 64 + RANK_FRACTION_BITS;
  localparam int DIV_CW = $clog2(DIV_W + 1);
  localparam int CFG_AW = 3;

  localparam logic [1:0] RK_HIT    = 2'd0;
  localparam logic [1:0] RK_ADMIT  = 2'd1;
  localparam logic [1:0] RK_REJECT = 2'd2;
  localparam logic [1:0] RK_EVICT  = 2'd3;

  localparam logic [0:0] REG_CAPACITY = 1'd0;
  localparam logic [31:0] CAPACITY_RESET = 32'd1048576;

  typedef struct packed {
    logic [31:0] object_id;
    logic [31:0] object_size;
    logic [31:0] next_use;
    logic [31:0] access_cost;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic [31:0] bytes_in_use;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] size;
    logic [63:0] rank;
    logic [31:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

FILE: sv/size_cost_oracle_cache_eviction_unit.sv
`default_nettype none
// An item goes through the rank divider (one multiply, then one quotient bit a cycle),
// then one pass around the entry ring and a result state, and for an admission
// one more ring pass and result per eviction plus a final placement pass.
// The unit takes one item at a time: no new item is taken until it is back in idle.
// Reset (synchronous, rst_n low) clears all valid bits, the byte count, the stamp
// counter and sets the capacity to 1048576 bytes; no clearing pass is needed.
// ----------------------------------------------------------------------------
// size_cost_oracle_cache_eviction_unit
// Oracle cache with eviction by greatest next_use*size/cost rank.
// ----------------------------------------------------------------------------
module size_cost_oracle_cache_eviction_unit
  import sco_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // The entries live in a ring of cells that rotates one place a cycle during a
  // pass. The entry at cell 0 is the one under inspection; its index is the step
  // count, so after a full pass the ring is back in its original order. The
  // controller may rewrite the head entry as it goes back into the tail.
  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_HSCAN, S_HOUT, S_ESCAN, S_EOUT, S_COMMIT
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         req_r, req_nxt;
  logic [31:0]      cap_r, cap_nxt;
  logic [32:0]      used_r, used_nxt;
  logic [31:0]      stamp_r, stamp_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] evn_r, evn_nxt;
  logic             found_r, found_nxt;
  logic [63:0]      rank_r, rank_nxt;
  entry_t           cand_r, cand_nxt;
  logic             vpend_r, vpend_nxt;
  logic [IDX_W-1:0] vidx_r, vidx_nxt;
  logic             placed_r, placed_nxt;
  logic             bv_r, bv_nxt;
  logic             bcand_r, bcand_nxt;
  logic [63:0]      brank_r, brank_nxt;
  logic [31:0]      bage_r, bage_nxt;
  logic [31:0]      bid_r, bid_nxt;
  logic [31:0]      bsize_r, bsize_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        oi_r, oi_nxt;

  entry_t           cell_q [ENTRIES];
  entry_t           head_mod;
  logic             shift_en;
  logic             div_start, div_done;
  logic [63:0]      div_rank;
  logic [31:0]      age;
  logic             better, last_step, out_free, cont;
  logic [CNT_W-1:0] cnt_dec;

  function automatic logic [31:0] sat_bytes(input logic [32:0] b);
    return b[32] ? 32'hFFFF_FFFF : b[31:0];
  endfunction

  // ---------------- ring of entries ----------------
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t d;
    if (g == ENTRIES - 1) begin : g_tail
      assign d = head_mod;
    end else begin : g_mid
      assign d = cell_q[g + 1];
    end
    sco_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[g])
    );
  end

  sco_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .size     (in_item.object_size),
    .next_use (in_item.next_use),
    .cost     (in_item.access_cost),
    .done     (div_done),
    .rank     (div_rank)
  );

  assign shift_en  = (state_r == S_HSCAN) || (state_r == S_ESCAN) || (state_r == S_COMMIT);
  assign in_stall  = (state_r != S_IDLE);
  assign div_start = in_valid && !in_stall;
  assign last_step = (step_r == IDX_W'(ENTRIES - 1));
  assign out_free  = !ov_r || !out_stall;
  assign cnt_dec   = cnt_r - 1'b1;

  // Head entry handling: a pending eviction is applied as the victim passes,
  // a hit is rewritten in place, and the new object drops into the first hole.
  always_comb begin
    head_mod = cell_q[0];
    if ((state_r == S_ESCAN || state_r == S_COMMIT) && vpend_r && vidx_r == step_r) begin
      head_mod.valid = 1'b0;
    end
    if (state_r == S_HSCAN && head_mod.valid && head_mod.id == req_r.object_id &&
        !found_r) begin
      head_mod.rank  = rank_r;
      head_mod.stamp = stamp_r;
    end
    age = stamp_r - head_mod.stamp;
    // The new object is the highest index, so an equal entry beats it.
    better = head_mod.valid &&
             (!bv_r || head_mod.rank > brank_r ||
              (head_mod.rank == brank_r && (age > bage_r || (age == bage_r && bcand_r))));
    if (state_r == S_COMMIT && !head_mod.valid && cand_r.valid && !placed_r) begin
      head_mod = cand_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    cap_nxt    = cap_r;
    used_nxt   = used_r;
    stamp_nxt  = stamp_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    evn_nxt    = evn_r;
    found_nxt  = found_r;
    rank_nxt   = rank_r;
    cand_nxt   = cand_r;
    vpend_nxt  = vpend_r;
    vidx_nxt   = vidx_r;
    placed_nxt = placed_r;
    bv_nxt     = bv_r;
    bcand_nxt  = bcand_r;
    brank_nxt  = brank_r;
    bage_nxt   = bage_r;
    bid_nxt    = bid_r;
    bsize_nxt  = bsize_r;
    bidx_nxt   = bidx_r;
    ov_nxt     = ov_r && out_stall;
    oi_nxt     = oi_r;
    cont       = 1'b0;

    if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      cap_nxt = pwdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (div_start) begin
          req_nxt   = in_item;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          rank_nxt  = div_rank;
          step_nxt  = '0;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_HSCAN;
        end
      end
      S_HSCAN: begin
        if (cell_q[0].valid) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cell_q[0].valid && cell_q[0].id == req_r.object_id) begin
          found_nxt = 1'b1;
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_HOUT;
        end
      end
      S_HOUT: begin
        if (out_free) begin
          ov_nxt              = 1'b1;
          oi_nxt.result_id    = req_r.object_id;
          oi_nxt.last_result  = 1'b1;
          state_nxt           = S_IDLE;
          if (found_r) begin
            oi_nxt.result_kind  = RK_HIT;
            oi_nxt.bytes_in_use = sat_bytes(used_r);
            stamp_nxt           = stamp_r + 1'b1;
          end else if (req_r.object_size > cap_r) begin
            oi_nxt.result_kind  = RK_REJECT;
            oi_nxt.bytes_in_use = sat_bytes(used_r);
          end else begin
            cand_nxt.valid = 1'b1;
            cand_nxt.id    = req_r.object_id;
            cand_nxt.size  = req_r.object_size;
            cand_nxt.rank  = rank_r;
            cand_nxt.stamp = stamp_r;
            stamp_nxt      = stamp_r + 1'b1;
            used_nxt       = used_r + {1'b0, req_r.object_size};
            cnt_nxt        = cnt_r + 1'b1;
            evn_nxt        = '0;
            vpend_nxt      = 1'b0;
            placed_nxt     = 1'b0;
            cont = (used_nxt > {1'b0, cap_r}) || (cnt_nxt > CNT_W'(ENTRIES));
            oi_nxt.result_kind  = RK_ADMIT;
            oi_nxt.bytes_in_use = sat_bytes(used_nxt);
            oi_nxt.last_result  = !cont;
            step_nxt            = '0;
            bv_nxt              = 1'b1;
            bcand_nxt           = 1'b1;
            brank_nxt           = rank_r;
            // The stamp counter has already moved past the new object's stamp.
            bage_nxt            = 32'd1;
            bid_nxt             = req_r.object_id;
            bsize_nxt           = req_r.object_size;
            state_nxt           = cont ? S_ESCAN : S_COMMIT;
          end
        end
      end
      S_ESCAN: begin
        if (better) begin
          bv_nxt    = 1'b1;
          bcand_nxt = 1'b0;
          brank_nxt = head_mod.rank;
          bage_nxt  = age;
          bid_nxt   = head_mod.id;
          bsize_nxt = head_mod.size;
          bidx_nxt  = step_r;
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          vpend_nxt = 1'b0;
          state_nxt = S_EOUT;
        end
      end
      S_EOUT: begin
        if (out_free) begin
          used_nxt = used_r - {1'b0, bsize_r};
          cnt_nxt  = cnt_dec;
          evn_nxt  = evn_r + 1'b1;
          if (bcand_r) begin
            cand_nxt.valid = 1'b0;
          end else begin
            vpend_nxt = 1'b1;
            vidx_nxt  = bidx_r;
          end
          cont = ((used_nxt > {1'b0, cap_r}) || (cnt_nxt > CNT_W'(ENTRIES))) &&
                 (evn_nxt < CNT_W'(ENTRIES)) && (cnt_nxt != '0);
          ov_nxt              = 1'b1;
          oi_nxt.result_kind  = RK_EVICT;
          oi_nxt.result_id    = bid_r;
          oi_nxt.bytes_in_use = sat_bytes(used_nxt);
          oi_nxt.last_result  = !cont;
          step_nxt            = '0;
          // Start the next search with the new object, if still held.
          bv_nxt    = cand_nxt.valid;
          bcand_nxt = 1'b1;
          brank_nxt = cand_r.rank;
          bage_nxt  = stamp_r - cand_r.stamp;
          bid_nxt   = cand_r.id;
          bsize_nxt = cand_r.size;
          state_nxt = cont ? S_ESCAN : S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (state_r == S_COMMIT && !cell_q[0].valid || (vpend_r && vidx_r == step_r)) begin
          if (cand_r.valid && !placed_r) begin
            placed_nxt = 1'b1;
          end
        end
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          vpend_nxt      = 1'b0;
          cand_nxt.valid = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CAPACITY_RESET;
      used_r   <= '0;
      stamp_r  <= '0;
      ov_r     <= 1'b0;
      vpend_r  <= 1'b0;
      cand_r.valid <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cap_r    <= cap_nxt;
      used_r   <= used_nxt;
      stamp_r  <= stamp_nxt;
      ov_r     <= ov_nxt;
      vpend_r  <= vpend_nxt;
      cand_r.valid <= cand_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    step_r       <= step_nxt;
    cnt_r        <= cnt_nxt;
    evn_r        <= evn_nxt;
    found_r      <= found_nxt;
    rank_r       <= rank_nxt;
    cand_r.id    <= cand_nxt.id;
    cand_r.size  <= cand_nxt.size;
    cand_r.rank  <= cand_nxt.rank;
    cand_r.stamp <= cand_nxt.stamp;
    vidx_r       <= vidx_nxt;
    placed_r     <= placed_nxt;
    bv_r         <= bv_nxt;
    bcand_r      <= bcand_nxt;
    brank_r      <= brank_nxt;
    bage_r       <= bage_nxt;
    bid_r        <= bid_nxt;
    bsize_r      <= bsize_nxt;
    bidx_r       <= bidx_nxt;
    oi_r         <= oi_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? cap_r : 32'd0;

endmodule
`default_nettype wire

FILE: sv/sco_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sco_cell
// One cache entry of the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module sco_cell
  import sco_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift_en,
  input  wire entry_t d_in,
  output entry_t      q
);

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift_en) begin
      ent_r.valid <= d_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r.id    <= d_in.id;
      ent_r.size  <= d_in.size;
      ent_r.rank  <= d_in.rank;
      ent_r.stamp <= d_in.stamp;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

FILE: sv/sco_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sco_div
// Rank unit: one multiply, then a restoring divide one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sco_div
  import sco_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] size,
  input  wire logic [31:0] next_use,
  input  wire logic [31:0] cost,
  output logic             done,
  output logic [63:0]      rank
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_RUN} state_t;

  state_t            state_r;
  logic [31:0]       a_r, b_r, cost_r;
  logic [DIV_W-1:0]  quo_r;
  logic [32:0]       rem_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              done_r;
  logic [63:0]       rank_r;

  logic [32:0]      rem_sh;
  logic             ge;
  logic [32:0]      rem_nxt;
  logic [DIV_W-1:0] quo_nxt;
  logic [63:0]      prod;

  assign prod    = 64'(a_r) * 64'(b_r);
  assign rem_sh  = {rem_r[31:0], quo_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, cost_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, cost_r} : rem_sh;
  assign quo_nxt = {quo_r[DIV_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r     <= size;
            b_r     <= next_use;
            cost_r  <= cost;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          quo_r   <= DIV_W'(prod) << RANK_FRACTION_BITS;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_CW'(DIV_W - 1)) begin
            // A zero cost or a quotient beyond 64 bits saturates.
            if (cost_r == '0 || (quo_nxt >> 64) != '0) begin
              rank_r <= '1;
            end else begin
              rank_r <= quo_nxt[63:0];
            end
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign rank = rank_r;

endmodule
`default_nettype wire

FILE: sv/sco_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sco_checker
// Port-level checks of the eviction unit, bound to the top level.
// ----------------------------------------------------------------------------
module sco_checker
  import sco_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A waiting result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // The unit works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // Hits and rejects are always the only result of their item.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == RK_HIT || out_item.result_kind == RK_REJECT)
      |-> out_item.last_result)
    else $error("hit or reject not marked last");

endmodule

bind size_cost_oracle_cache_eviction_unit sco_checker u_sco_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

FILE: sim/size_cost_oracle_cache_eviction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_cost_oracle_cache_eviction_checker
// Watches the request, result and register ports of the eviction unit. It keeps
// its own copy of the cache table, works out the results of every accepted
// request, and compares each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module size_cost_oracle_cache_eviction_checker
  import sco_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire in_item_t          in_item,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire out_item_t         out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic              pready,
  output int                     fail_count,
  output int                     pending
);

  // Slot ENTRIES holds the newly admitted object beside the table.
  logic        slot_valid [ENTRIES+1];
  logic [31:0] slot_id    [ENTRIES+1];
  logic [31:0] slot_size  [ENTRIES+1];
  logic [63:0] slot_rank  [ENTRIES+1];
  logic [31:0] slot_stamp [ENTRIES+1];
  logic [32:0] bytes_held;
  logic [31:0] stamp_next;
  logic [31:0] capacity;

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] fetch_rank(logic [31:0] size, logic [31:0] nxt,
                                             logic [31:0] cost);
    logic [63:0] prod, quo, rem, frac;
    if (cost == 0) return '1;
    prod = 64'(size) * 64'(nxt);
    quo  = prod / 64'(cost);
    rem  = prod % 64'(cost);
    if (RANK_FRACTION_BITS > 0 && (quo >> (64 - RANK_FRACTION_BITS)) != 0) return '1;
    frac = (rem << RANK_FRACTION_BITS) / 64'(cost);
    return (quo << RANK_FRACTION_BITS) | frac;
  endfunction

  task automatic push_result(logic [1:0] kind, logic [31:0] id);
    out_item_t r;
    r.result_kind  = kind;
    r.result_id    = id;
    r.bytes_in_use = bytes_held[32] ? 32'hFFFF_FFFF : bytes_held[31:0];
    r.last_result  = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic predict_request(in_item_t req);
    int count, evicted, victim;
    logic [31:0] vage, age;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_id[i] == req.object_id) begin
        slot_rank[i]  = fetch_rank(req.object_size, req.next_use, req.access_cost);
        slot_stamp[i] = stamp_next;
        stamp_next++;
        push_result(RK_HIT, req.object_id);
        expected_results[$].last_result = 1'b1;
        return;
      end
    end
    if (req.object_size > capacity) begin
      push_result(RK_REJECT, req.object_id);
      expected_results[$].last_result = 1'b1;
      return;
    end
    slot_valid[ENTRIES] = 1'b1;
    slot_id[ENTRIES]    = req.object_id;
    slot_size[ENTRIES]  = req.object_size;
    slot_rank[ENTRIES]  = fetch_rank(req.object_size, req.next_use, req.access_cost);
    slot_stamp[ENTRIES] = stamp_next;
    stamp_next++;
    bytes_held = bytes_held + 33'(req.object_size);
    count = 0;
    for (int i = 0; i <= ENTRIES; i++) if (slot_valid[i]) count++;
    push_result(RK_ADMIT, req.object_id);
    evicted = 0;
    while ((bytes_held > 33'(capacity) || count > ENTRIES) && evicted < ENTRIES) begin
      victim = -1;
      vage = 0;
      for (int i = 0; i <= ENTRIES; i++) begin
        if (!slot_valid[i]) continue;
        age = stamp_next - slot_stamp[i];
        // Greatest rank goes first; among equal ranks the oldest stamp.
        if (victim < 0 || slot_rank[i] > slot_rank[victim] ||
            (slot_rank[i] == slot_rank[victim] && age > vage)) begin
          victim = i;
          vage = age;
        end
      end
      if (victim < 0) break;
      slot_valid[victim] = 1'b0;
      bytes_held = bytes_held - 33'(slot_size[victim]);
      count--;
      evicted++;
      push_result(RK_EVICT, slot_id[victim]);
    end
    if (slot_valid[ENTRIES]) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_id[i]    = slot_id[ENTRIES];
          slot_size[i]  = slot_size[ENTRIES];
          slot_rank[i]  = slot_rank[ENTRIES];
          slot_stamp[i] = slot_stamp[ENTRIES];
          break;
        end
      end
      slot_valid[ENTRIES] = 1'b0;
    end
    expected_results[$].last_result = 1'b1;
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: kind %0d id %0h", got.result_kind, got.result_id);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
      fail_count++;
    end
    if (got.result_id !== want.result_id) begin
      $error("result_id expected %0h actual %0h", want.result_id, got.result_id);
      fail_count++;
    end
    if (got.bytes_in_use !== want.bytes_in_use) begin
      $error("bytes_in_use expected %0d actual %0d", want.bytes_in_use, got.bytes_in_use);
      fail_count++;
    end
    if (got.last_result !== want.last_result) begin
      $error("last_result expected %0d actual %0d", want.last_result, got.last_result);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= ENTRIES; i++) slot_valid[i] = 1'b0;
      bytes_held = '0;
      stamp_next = '0;
      capacity   = CAPACITY_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CFG_AW'(REG_CAPACITY) * 4)
        capacity = pwdata;
      if (in_valid && !in_stall) predict_request(in_item);
      if (out_valid && !out_stall) compare_result(out_item);
    end
  end

endmodule

FILE: sim/size_cost_oracle_cache_eviction_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_cost_oracle_cache_eviction_unit_test
// Drives requests and capacity writes into the eviction unit under random
// gaps and result stalls; a checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module size_cost_oracle_cache_eviction_unit_test;
  import sco_pkg::*;

  // Cycles the unit may still be busy after its last result: a full placement
  // pass and then some.
  localparam int SETTLE_CYCLES = 1500;
  localparam int HOLD_CYCLES   = 4000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  int  requests_sent;
  int  capacity_writes;
  int  reg_errors;
  bit  gapless;      // when set, neither side idles
  bit  hold_request; // asks the receiver for one long stall

  size_cost_oracle_cache_eviction_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  size_cost_oracle_cache_eviction_checker watcher (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung unit.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: stall for a drawn number of cycles before taking each item.
  // A hold request keeps the stall up long enough for the unit to back up.
  initial begin : receiver
    int n;
    out_stall = 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      n = gapless ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One request item. The valid is lowered only when a gap follows, so it is
  // never lowered and raised in the same step.
  task automatic send_request(logic [31:0] id, logic [31:0] size, logic [31:0] nxt,
                              logic [31:0] cost);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{object_id: id, object_size: size, next_use: nxt, access_cost: cost};
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Let every expected result arrive and the unit finish its placement pass.
  // It waits on the clock first, so the checker has predicted the last accepted item.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity write in setup and access cycles, then a read back of the register.
  task automatic write_capacity(logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(REG_CAPACITY * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) begin
      $error("cache_capacity expected %0h actual %0h", value, prdata);
      reg_errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    capacity_writes++;
  endtask

  // Random request: ids mostly from a small pool so hits are common, sizes
  // scaled to the capacity, and now and then a fully random field.
  task automatic random_request(logic [31:0] size_cap);
    logic [31:0] id, size, nxt, cost;
    id   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 47);
    size = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, size_cap);
    nxt  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5000);
    cost = ($urandom_range(0, 9) == 0) ? 32'd0 :
           ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 64);
    send_request(id, size, nxt, cost);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gapless = 1'b0; hold_request = 1'b0;
    requests_sent = 0; capacity_writes = 0; reg_errors = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset capacity.
    send_request(32'd1, 32'd100, 32'd10, 32'd3);               // plain admission
    send_request(32'd1, 32'd50, 32'd20, 32'd1);                // hit, size not stored
    send_request(32'd2, 32'h0010_0001, 32'd1, 32'd1);          // too large, rejected
    send_request(32'd3, 32'h0010_0000, 32'd0, 32'd0);          // zero cost, admitted then evicted
    send_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1);  // zero size, extreme id
    send_request(32'd4, 32'hFFFF, 32'hFFFF_FFFF, 32'd1);       // large rank, below saturation
    send_request(32'd5, 32'd7, 32'd9, 32'hFFFF_FFFF);          // tiny rank
    send_request(32'd0, 32'd8, 32'd8, 32'd8);                  // equal ranks, oldest first
    send_request(32'd6, 32'd8, 32'd8, 32'd8);
    send_request(32'd7, 32'd300000, 32'd8, 32'd8);

    // Full table: 34 equal-rank objects of one byte force count evictions.
    write_capacity(32'hFFFF_FFFF);
    gapless = 1'b1;
    for (int i = 0; i < 34; i++) send_request(32'd100 + i, 32'd1, 32'd2, 32'd2);
    gapless = 1'b0;
    send_request(32'd200, 32'hFFFF_FFFF, 32'd3, 32'd1);        // byte count passes 32 bits
    send_request(32'd201, 32'hFFFF_FFFF, 32'd3, 32'd7);

    // Lowered capacity leaves excess that later admissions clear.
    write_capacity(32'd0);
    send_request(32'd300, 32'd0, 32'd1, 32'd1);
    send_request(32'd301, 32'd1, 32'd1, 32'd1);

    // Random phases across capacity settings; one phase holds the result side.
    write_capacity(32'd4096);
    hold_request = 1'b1;
    for (int i = 0; i < 20; i++) random_request(32'd700);
    write_capacity(32'hFFFF_FFFF);
    gapless = 1'b1;
    for (int i = 0; i < 10; i++) random_request(32'hFFFF_FFFF);
    gapless = 1'b0;
    for (int i = 0; i < 10; i++) random_request(32'h7FFF_FFFF);
    write_capacity(32'd1000);
    for (int i = 0; i < 20; i++) random_request(32'd300);

    drain();
    $display("Sent %0d requests over %0d capacity settings, from zero to full range,",
             requests_sent, capacity_writes + 1);
    $display("with hits, rejections, forced evictions, rank saturation and stalls.");
    if (fail_count == 0 && reg_errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sco_pkg.sv
sv/sco_cell.sv
sv/sco_div.sv
sv/size_cost_oracle_cache_eviction_unit.sv
sv/sco_checker.sv
sim/size_cost_oracle_cache_eviction_checker.sv
sim/size_cost_oracle_cache_eviction_unit_test.sv
